// ===== rtl/ecc_pkg.sv =====
// ----------------------------------------------------------------------------
// ecc_pkg: shared constants for the epoch/calendar converter
// Field widths, calendar constants and the month start table.
// ----------------------------------------------------------------------------
`default_nettype none

package ecc_pkg;

  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 104;

  localparam logic [11:0] YEAR_BASE    = 12'd1970;
  localparam logic [11:0] YEAR_LAST    = 12'd2099;
  localparam logic [11:0] YEAR_LEAPREF = 12'd1969;

  localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;
  localparam logic [15:0] DAY_PER_YEAR = 16'd365;

  // Constant divisors for the reciprocal dividers
  localparam int unsigned DAY_SHIFT     = 7;     // 86400 = 675 << 7
  localparam int unsigned DAY_DIV       = 675;
  localparam int unsigned DAY_PER_CYCLE = 1461;
  localparam int unsigned HOUR_DIV      = 3600;
  localparam int unsigned MIN_DIV       = 60;

  // Start of each year inside the four-year cycle; the third year is leap
  localparam logic [10:0] CYC_Y1 = 11'd365;
  localparam logic [10:0] CYC_Y2 = 11'd730;
  localparam logic [10:0] CYC_Y3 = 11'd1096;

  // Zero-based day of year at which a month starts, common year
  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] res;
    unique case (mon)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd59;
      4'd3:    res = 9'd90;
      4'd4:    res = 9'd120;
      4'd5:    res = 9'd151;
      4'd6:    res = 9'd181;
      4'd7:    res = 9'd212;
      4'd8:    res = 9'd243;
      4'd9:    res = 9'd273;
      4'd10:   res = 9'd304;
      4'd11:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // Per-beat context that travels down the pipeline
  typedef struct packed {
    logic        func;
    logic        bad;
    logic [31:0] frac;
    logic [6:0]  e_lo;
    logic [15:0] days0;
    logic [16:0] hms;
    logic [31:0] epoch_res;
    logic [11:0] year;
    logic        leap;
    logic [8:0]  doy;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [4:0]  hour;
  } ctx_t;

endpackage

`default_nettype wire

// ===== rtl/ecc_const_div.sv =====
// ----------------------------------------------------------------------------
// ecc_const_div: three-stage divider by a constant
// Multiplies by a truncated reciprocal, forms the remainder and applies a
// single compare-and-subtract fix. Each stage loads on its own advance bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_const_div #(
  parameter int unsigned XW = 16,
  parameter int unsigned D  = 10
) (
  input  logic                  clk_i,
  input  logic [2:0]            adv_i,
  input  logic [XW-1:0]         x_i,
  output logic [XW-$clog2(D):0] q_o,
  output logic [$clog2(D)-1:0]  r_o
);

  localparam int unsigned RW  = $clog2(D);
  localparam int unsigned RW1 = RW + 1;
  localparam int unsigned QW  = XW - RW + 1;
  localparam int unsigned PW  = XW + QW;
  localparam longint unsigned RECIP_FULL = (64'd1 << XW) / D;
  localparam logic [QW-1:0]  RECIP = QW'(RECIP_FULL);
  localparam logic [XW-1:0]  DIV_X = XW'(D);
  localparam logic [RW1-1:0] DIV_R = RW1'(D);

  logic [XW-1:0]  x_a_q;
  logic [PW-1:0]  p_a_d, p_a_q;
  logic [QW-1:0]  q_b_d, q_b_q;
  logic [XW-1:0]  qd_b, r_full;
  logic [RW1-1:0] r_b_d, r_b_q;
  logic [QW-1:0]  q_c_d, q_c_q;
  logic [RW-1:0]  r_c_d, r_c_q;

  assign p_a_d = PW'(x_i) * PW'(RECIP);

  // Estimate is the true quotient or one short
  assign q_b_d  = p_a_q[PW-1:XW];
  assign qd_b   = XW'(q_b_d) * DIV_X;
  assign r_full = x_a_q - qd_b;
  assign r_b_d  = r_full[RW:0];

  always_comb begin
    if (r_b_q >= DIV_R) begin
      q_c_d = q_b_q + QW'(1);
      r_c_d = RW'(r_b_q - DIV_R);
    end else begin
      q_c_d = q_b_q;
      r_c_d = r_b_q[RW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      x_a_q <= x_i;
      p_a_q <= p_a_d;
    end
    if (adv_i[1]) begin
      q_b_q <= q_b_d;
      r_b_q <= r_b_d;
    end
    if (adv_i[2]) begin
      q_c_q <= q_c_d;
      r_c_q <= r_c_d;
    end
  end

  assign q_o = q_c_q;
  assign r_o = r_c_q;

endmodule

`default_nettype wire

// ===== rtl/epoch_calendar_converter.sv =====
// ----------------------------------------------------------------------------
// epoch_calendar_converter: calendar date/time <-> seconds since 1970
// Stateless nine-stage pipeline converting in either direction per beat.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless the output side stalls it, and returns one
// result beat for each, in order. The pipeline depth is set by the
// epoch-to-date path: three chained constant dividers (seconds to days,
// days to four-year cycles alongside seconds to hours, and seconds to
// minutes), each three register stages deep. Every stage holds its beat while
// the stage after it is full and cannot move, so a downstream stall fills the
// empty slots before the input side stops. tuser on the input selects the
// direction (0 = date to epoch, 1 = epoch to date); tuser on the output
// flags a date field out of range, in which case the epoch field is zero.
// Every fourth year counts as a leap year, and month lengths are not checked.
`default_nettype none

module epoch_calendar_converter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // year[11:0] month[15:12] day[20:16] hour[25:21] minute[31:26]
  // second[37:32] fraction[69:38] epoch[101:70], zero pad above
  input  logic [ecc_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic [0:0]                     s_axis_tuser_i,  // func
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // epoch[31:0] year[43:32] month[47:44] day[52:48] hour[57:53]
  // minute[63:58] second[69:64] fraction[101:70], zero pad above
  output logic [ecc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [0:0]                      m_axis_tuser_o,  // invalid
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);

  import ecc_pkg::*;

  localparam int unsigned NSTG = 9;

  logic [NSTG-1:0] vld_q, vld_in, en;
  ctx_t            st_q [NSTG];
  ctx_t            st_d [NSTG];

  // Input fields
  logic [11:0] year_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in, hour_in;
  logic [5:0]  minute_in, second_in;
  logic [31:0] fraction_in, epoch_in;

  assign year_in     = s_axis_tdata_i[11:0];
  assign month_in    = s_axis_tdata_i[15:12];
  assign day_in      = s_axis_tdata_i[20:16];
  assign hour_in     = s_axis_tdata_i[25:21];
  assign minute_in   = s_axis_tdata_i[31:26];
  assign second_in   = s_axis_tdata_i[37:32];
  assign fraction_in = s_axis_tdata_i[69:38];
  assign epoch_in    = s_axis_tdata_i[101:70];

  // Divider results
  logic [15:0] days;
  logic [9:0]  day_r;
  logic [16:0] sod;
  logic [5:0]  cyc;
  logic [10:0] crem;
  logic [5:0]  hr_q;
  logic [11:0] soh;
  logic [6:0]  min_q;
  logic [5:0]  min_r;

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or the next one moves
  // --------------------------------------------------------------------------
  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vld_in          = {vld_q[NSTG-2:0], s_axis_tvalid_i};
  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

  // --------------------------------------------------------------------------
  // Dividers
  // --------------------------------------------------------------------------
  ecc_const_div #(.XW(32 - DAY_SHIFT), .D(DAY_DIV)) u_div_day (
    .clk_i (clk_i),
    .adv_i (en[2:0]),
    .x_i   (epoch_in[31:DAY_SHIFT]),
    .q_o   (days),
    .r_o   (day_r)
  );

  assign sod = {day_r, st_q[2].e_lo};

  ecc_const_div #(.XW(16), .D(DAY_PER_CYCLE)) u_div_cyc (
    .clk_i (clk_i),
    .adv_i (en[5:3]),
    .x_i   (days),
    .q_o   (cyc),
    .r_o   (crem)
  );

  ecc_const_div #(.XW(17), .D(HOUR_DIV)) u_div_hour (
    .clk_i (clk_i),
    .adv_i (en[5:3]),
    .x_i   (sod),
    .q_o   (hr_q),
    .r_o   (soh)
  );

  ecc_const_div #(.XW(12), .D(MIN_DIV)) u_div_min (
    .clk_i (clk_i),
    .adv_i (en[8:6]),
    .x_i   (soh),
    .q_o   (min_q),
    .r_o   (min_r)
  );

  // --------------------------------------------------------------------------
  // Stage logic
  // --------------------------------------------------------------------------
  logic [7:0]  ydiff;
  logic [6:0]  leap_days;
  logic        leap_in;
  logic [15:0] days0;
  logic [16:0] hms;
  logic [1:0]  yr;
  logic [10:0] ystart;
  logic [3:0]  mon;
  logic [8:0]  mst, ms;

  always_comb begin
    ydiff     = 8'(year_in - YEAR_BASE);
    leap_days = 7'(10'(year_in - YEAR_LEAPREF) >> 2);
    leap_in   = (year_in[1:0] == 2'd0) && (month_in > 4'd2);
    days0     = 16'(ydiff) * DAY_PER_YEAR + 16'(leap_days)
              + 16'(month_start(month_in - 4'd1)) + 16'(day_in)
              + 16'(leap_in) - 16'd1;
    hms       = 17'(hour_in) * SEC_PER_HOUR + 17'(minute_in) * SEC_PER_MIN
              + 17'(second_in);

    // Stage 0: date fields to day count and second of day
    st_d[0]       = '0;
    st_d[0].func  = s_axis_tuser_i[0];
    st_d[0].bad   = !s_axis_tuser_i[0] &&
                    (year_in < YEAR_BASE || year_in > YEAR_LAST ||
                     month_in < 4'd1 || month_in > 4'd12 || day_in < 5'd1 ||
                     hour_in > 5'd23 || minute_in > 6'd59 || second_in > 6'd59);
    st_d[0].frac  = fraction_in;
    st_d[0].e_lo  = epoch_in[DAY_SHIFT-1:0];
    st_d[0].days0 = days0;
    st_d[0].hms   = hms;

    // Stage 1: epoch seconds; zero on a bad field or the other direction
    st_d[1] = st_q[0];
    if (st_q[0].func || st_q[0].bad) begin
      st_d[1].epoch_res = '0;
    end else begin
      st_d[1].epoch_res = 32'(st_q[0].days0) * SEC_PER_DAY + 32'(st_q[0].hms);
    end

    st_d[2] = st_q[1];
    st_d[3] = st_q[2];
    st_d[4] = st_q[3];
    st_d[5] = st_q[4];

    // Stage 6: year from the four-year cycle, leap flag, day of year and hour
    if (crem < CYC_Y1) begin
      yr = 2'd0; ystart = '0;
    end else if (crem < CYC_Y2) begin
      yr = 2'd1; ystart = CYC_Y1;
    end else if (crem < CYC_Y3) begin
      yr = 2'd2; ystart = CYC_Y2;
    end else begin
      yr = 2'd3; ystart = CYC_Y3;
    end
    st_d[6]      = st_q[5];
    st_d[6].year = st_q[5].func ? 12'(YEAR_BASE + {cyc, 2'b00} + 12'(yr)) : '0;
    st_d[6].leap = (yr == 2'd2);
    st_d[6].doy  = 9'(crem - ystart);
    st_d[6].hour = st_q[5].func ? hr_q[4:0] : '0;

    // Stage 7: month and day of month
    mon = '0;
    mst = '0;
    for (int m = 1; m < 12; m++) begin
      ms = month_start(4'(m)) + 9'((st_q[6].leap && m >= 2) ? 1 : 0);
      if (st_q[6].doy >= ms) begin
        mon = 4'(m);
        mst = ms;
      end
    end
    st_d[7]       = st_q[6];
    st_d[7].month = st_q[6].func ? mon + 4'd1 : '0;
    st_d[7].dom   = st_q[6].func ? 5'(st_q[6].doy - mst + 9'd1) : '0;

    st_d[8] = st_q[7];
  end

  // --------------------------------------------------------------------------
  // Output beat
  // --------------------------------------------------------------------------
  logic [5:0] minute_o, second_o;

  assign minute_o = st_q[8].func ? min_q[5:0] : '0;
  assign second_o = st_q[8].func ? min_r : '0;

  assign m_axis_tvalid_o = vld_q[NSTG-1];
  assign m_axis_tuser_o  = st_q[8].bad;
  assign m_axis_tdata_o  = {2'b00, st_q[8].frac, second_o, minute_o, st_q[8].hour,
                            st_q[8].dom, st_q[8].month, st_q[8].year,
                            st_q[8].epoch_res};

`ifndef NO_ASSERTIONS
  // Input side stalls only with every stage full and the output blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> ((&vld_q) && !m_axis_tready_i))
    else $error("input stalled with room in the pipeline");

  // A flagged beat carries no epoch and no date
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (m_axis_tdata_o[31:0] == 32'd0 && m_axis_tdata_o[69:32] == 38'd0))
    else $error("invalid beat with nonzero fields");

  // A converted date stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[47:44] != 4'd0) |->
      (m_axis_tdata_o[47:44] <= 4'd12 && m_axis_tdata_o[52:48] != 5'd0 &&
       m_axis_tdata_o[57:53] <= 5'd23 && m_axis_tdata_o[63:58] <= 6'd59 &&
       m_axis_tdata_o[69:64] <= 6'd59 && m_axis_tdata_o[31:0] == 32'd0 &&
       !m_axis_tuser_o[0]))
    else $error("date field out of range");

  // A held output beat is not overwritten by the stage behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(st_q[8]))
    else $error("output stage changed under stall");
`endif

endmodule

`default_nettype wire
